### rtl/core/fel_pkg.sv
// Shared types and constants for the fault event logger.
// No dependencies; every other file of the block imports this package.
package fel_pkg;

	localparam int LOG_DEPTH        = 32;
	localparam int FAULT_WORD_COUNT = 4;
	localparam int WORD_W           = 16;
	localparam int NUM_BITS         = FAULT_WORD_COUNT * WORD_W;
	localparam int BIT_W            = $clog2(NUM_BITS);
	localparam int IDX_W            = $clog2(LOG_DEPTH);
	localparam int FAULT_W          = 64;
	localparam int CODE_W           = 7;
	localparam int COUNT_W          = 7;
	localparam int TIME_W           = 16;
	localparam int SEL_W            = 16;
	localparam int SEL_OUT_W        = 5;
	localparam int DISP_W           = 12;
	localparam int DISP_SCALE       = 100;

	// One ring slot: fault code plus the three raw timestamp words.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [TIME_W-1:0] t0;
		logic [TIME_W-1:0] t1;
		logic [TIME_W-1:0] t2;
	} log_entry_t;

	// Write request from the bit scanner to the ring.
	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] code;
	} log_wr_t;

	// Scanner status toward the sequencer.
	typedef struct packed {
		logic busy;
		logic last;
	} scan_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_SHOW
	} fel_state_t;

endpackage

### rtl/core/fel_in_if.sv
// Input channel of the fault event logger: valid/ready plus one tick's fields.
// Depends on fel_pkg for field widths.
interface fel_in_if import fel_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [FAULT_W-1:0] fault_bits;
	logic [TIME_W-1:0]  time_sec_hundredth;
	logic [TIME_W-1:0]  time_hour_minute;
	logic [TIME_W-1:0]  time_month_day;
	logic               clear_cmd;
	logic [SEL_W-1:0]   display_select;

	modport source (
		output valid, fault_bits, time_sec_hundredth, time_hour_minute,
			time_month_day, clear_cmd, display_select,
		input  ready
	);
	modport sink (
		input  valid, fault_bits, time_sec_hundredth, time_hour_minute,
			time_month_day, clear_cmd, display_select,
		output ready
	);
endinterface

### rtl/core/fel_out_if.sv
// Output channel of the fault event logger: valid/ready plus one result's fields.
// Depends on fel_pkg for field widths.
interface fel_out_if import fel_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [COUNT_W-1:0]   active_count;
	logic                 save_request;
	logic [SEL_OUT_W-1:0] select_used;
	logic [DISP_W-1:0]    display_number;
	logic [TIME_W-1:0]    display_time0;
	logic [TIME_W-1:0]    display_time1;
	logic [TIME_W-1:0]    display_time2;

	modport source (
		output valid, active_count, save_request, select_used, display_number,
			display_time0, display_time1, display_time2,
		input  ready
	);
	modport sink (
		input  valid, active_count, save_request, select_used, display_number,
			display_time0, display_time1, display_time2,
		output ready
	);
endinterface

### rtl/core/fel_scan.sv
// Bit-serial fault scanner: shifts current and previous fault vectors one bit
// per cycle, counts set bits and issues a ring write for each rising bit. Uses fel_pkg.
module fel_scan import fel_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] bits,
	output log_wr_t             wr,
	output scan_stat_t          stat,
	output logic [COUNT_W-1:0]  count
);

	logic [NUM_BITS-1:0] cur_q;
	logic [NUM_BITS-1:0] prev_q;
	logic [BIT_W-1:0]    pos_q;
	logic [COUNT_W-1:0]  count_q;
	logic                busy_q;
	logic                last_bit;

	assign last_bit = busy_q && (pos_q == BIT_W'(NUM_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pos_q   <= '0;
			count_q <= '0;
			prev_q  <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			pos_q   <= '0;
			count_q <= '0;
		end else if (busy_q) begin
			// rotate the new bit in behind the old one: after a full pass
			// prev_q holds this tick's vector
			prev_q  <= {cur_q[0], prev_q[NUM_BITS-1:1]};
			count_q <= count_q + COUNT_W'(cur_q[0]);
			pos_q   <= pos_q + BIT_W'(1);
			if (last_bit) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= bits;
		end else if (busy_q) begin
			cur_q <= cur_q >> 1;
		end
	end

	assign wr.valid  = busy_q && cur_q[0] && !prev_q[0];
	assign wr.code   = CODE_W'(pos_q) + CODE_W'(1);
	assign stat.busy = busy_q;
	assign stat.last = last_bit;
	assign count     = count_q;

	a_wr_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid |-> busy_q)
		else $error("ring write outside of a scan");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> (count_q <= COUNT_W'(NUM_BITS)))
		else $error("active count above the number of fault bits");

endmodule

### rtl/core/fel_log.sv
// Fault ring: entry memory, per-slot valid bits, write index and the
// registered display read. Uses fel_pkg.
module fel_log import fel_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  log_wr_t           wr,
	input  logic [TIME_W-1:0] ts0,
	input  logic [TIME_W-1:0] ts1,
	input  logic [TIME_W-1:0] ts2,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_sel,
	output log_entry_t        rd_entry
);

	log_entry_t           mem [LOG_DEPTH];
	logic [LOG_DEPTH-1:0] valid_q;
	logic [IDX_W-1:0]     index_q;
	logic [IDX_W-1:0]     index_next;
	logic [IDX_W-1:0]     rd_addr;
	log_entry_t           rd_data_q;
	logic                 rd_valid_q;

	assign index_next = (index_q == IDX_W'(LOG_DEPTH - 1)) ? '0 : index_q + IDX_W'(1);

	// count back from the newest slot, wrapping around the ring
	always_comb begin
		if (index_q >= rd_sel) begin
			rd_addr = index_q - rd_sel;
		end else begin
			rd_addr = IDX_W'((IDX_W+1)'(index_q) + (IDX_W+1)'(LOG_DEPTH)
				- (IDX_W+1)'(rd_sel));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			index_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
				index_q <= '0;
			end else if (wr.valid) begin
				valid_q[index_next] <= 1'b1;
				index_q             <= index_next;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			mem[index_next] <= '{code: wr.code, t0: ts0, t1: ts1, t2: ts2};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// a slot never written since the last clear reads as all zero
	assign rd_entry = rd_valid_q ? rd_data_q : '0;

	a_no_clear_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(clear && wr.valid))
		else $error("ring clear and ring write in the same cycle");

endmodule

### rtl/core/fault_event_logger.sv
// Fault event logger top level: sequencer, tick capture and result register.
// Depends on fel_pkg, fel_in_if, fel_out_if, fel_scan and fel_log.

// One item is one tick. The logger counts the set fault bits, stores a ring
// entry (code word*16+bit+1 plus the three raw timestamp words) for every bit
// that rose since the previous tick, in word then bit order, and returns one
// result: the active count, a save request (log cleared or written), and the
// entry chosen by counting display_select back from the newest slot, shown as
// select*100 + code together with its timestamp words. A selector at or above
// the ring depth shows as 0; an empty slot reads as code 0 with zero times.
// clear_cmd empties the ring and resets the write index before the tick is
// scanned, so the first entry afterwards lands in slot 1. Each item passes
// through a one-bit-per-cycle scanner, then the ring read (ST_READ), then
// ST_SHOW, where the display number is formed and loaded into the result
// register once the previous result has been taken. A waiting result does
// not stop the next item from being taken and scanned; a new item is taken
// whenever the sequencer is idle. After reset the ring is empty at once,
// with no clearing pass.
module fault_event_logger import fel_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fel_in_if.sink     in_ch,
	fel_out_if.source  out_ch
);

	fel_state_t           state_q;
	fel_state_t           state_d;
	logic                 in_acc;
	logic                 out_load;
	logic                 rd_en;

	// tick capture
	logic [TIME_W-1:0]    ts0_q;
	logic [TIME_W-1:0]    ts1_q;
	logic [TIME_W-1:0]    ts2_q;
	logic [IDX_W-1:0]     sel_q;
	logic                 save_q;
	logic [IDX_W-1:0]     sel_in;

	// result register
	logic                 out_valid_q;
	logic [COUNT_W-1:0]   count_out_q;
	logic                 save_out_q;
	logic [SEL_OUT_W-1:0] sel_out_q;
	logic [DISP_W-1:0]    disp_out_q;
	logic [TIME_W-1:0]    t0_out_q;
	logic [TIME_W-1:0]    t1_out_q;
	logic [TIME_W-1:0]    t2_out_q;

	log_wr_t              wr;
	scan_stat_t           stat;
	logic [COUNT_W-1:0]   count;
	log_entry_t           rd_entry;
	logic [SEL_W-1:0]     sel_wide;
	logic [SEL_W-1:0]     disp_wide;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	// force an out-of-range selector to the newest entry
	assign sel_in = (in_ch.display_select >= SEL_W'(LOG_DEPTH)) ? '0
		: IDX_W'(in_ch.display_select);

	fel_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.bits   (in_ch.fault_bits[NUM_BITS-1:0]),
		.wr     (wr),
		.stat   (stat),
		.count  (count)
	);

	fel_log u_log (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (in_acc && in_ch.clear_cmd),
		.wr       (wr),
		.ts0      (ts0_q),
		.ts1      (ts1_q),
		.ts2      (ts2_q),
		.rd_en    (rd_en),
		.rd_sel   (sel_q),
		.rd_entry (rd_entry)
	);

	// sequencer: scan, read the ring, then hand the result to the output register
	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.last) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				// hold until the previous result has been taken
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			save_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			// save request: raised by a clear, or by any ring write of this tick
			if (in_acc) begin
				save_q <= in_ch.clear_cmd;
			end else if (wr.valid) begin
				save_q <= 1'b1;
			end
		end
	end

	// capture the tick's timestamp and selector
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ts0_q <= in_ch.time_sec_hundredth;
			ts1_q <= in_ch.time_hour_minute;
			ts2_q <= in_ch.time_month_day;
			sel_q <= sel_in;
		end
	end

	assign sel_wide  = SEL_W'(sel_q);
	assign disp_wide = sel_wide * SEL_W'(DISP_SCALE) + SEL_W'(rd_entry.code);

	always_ff @(posedge clk) begin
		if (out_load) begin
			count_out_q <= count;
			save_out_q  <= save_q;
			sel_out_q   <= sel_wide[SEL_OUT_W-1:0];
			disp_out_q  <= disp_wide[DISP_W-1:0];
			t0_out_q    <= rd_entry.t0;
			t1_out_q    <= rd_entry.t1;
			t2_out_q    <= rd_entry.t2;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.active_count   = count_out_q;
	assign out_ch.save_request   = save_out_q;
	assign out_ch.select_used    = sel_out_q;
	assign out_ch.display_number = disp_out_q;
	assign out_ch.display_time0  = t0_out_q;
	assign out_ch.display_time1  = t1_out_q;
	assign out_ch.display_time2  = t2_out_q;

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_SCAN) && stat.busy)
		else $error("accepted item did not start a scan");

endmodule

### dv/fel_log_monitor.sv
// Prediction and comparison for the fault event logger testbench.
// Depends on fel_pkg, fel_in_if and fel_out_if; watches both channels and never drives them.
module fel_log_monitor import fel_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	fel_in_if           in_ch,
	fel_out_if          out_ch,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef struct packed {
		logic [COUNT_W-1:0]   active_count;
		logic                 save_request;
		logic [SEL_OUT_W-1:0] select_used;
		logic [DISP_W-1:0]    display_number;
		logic [TIME_W-1:0]    time0;
		logic [TIME_W-1:0]    time1;
		logic [TIME_W-1:0]    time2;
	} log_view_t;

	log_entry_t         slots [LOG_DEPTH];
	int unsigned        newest;
	logic [FAULT_W-1:0] last_faults;
	log_view_t          pending_views [$];
	int unsigned        result_no;
	log_view_t          got;
	log_view_t          want;

	function automatic void wipe_log();
		for (int i = 0; i < LOG_DEPTH; i++)
			slots[i] = '0;
		newest = 0;
	endfunction

	// Apply one tick to the shadow ring and return the view it should produce.
	function automatic log_view_t log_tick(input logic [FAULT_W-1:0] faults,
			input logic [TIME_W-1:0] ts0, input logic [TIME_W-1:0] ts1,
			input logic [TIME_W-1:0] ts2, input logic clr,
			input logic [SEL_W-1:0] sel_in);
		log_view_t         view;
		logic [WORD_W-1:0] cur;
		logic [WORD_W-1:0] rose;
		int unsigned       cnt;
		int unsigned       sel;
		int unsigned       shown;
		view = '0;
		cnt  = 0;
		if (clr || newest >= LOG_DEPTH) begin
			wipe_log();
			view.save_request = 1'b1;
		end
		for (int w = 0; w < FAULT_WORD_COUNT; w++) begin
			cur  = faults[w*WORD_W +: WORD_W];
			rose = cur & ~last_faults[w*WORD_W +: WORD_W];
			last_faults[w*WORD_W +: WORD_W] = cur;
			for (int b = 0; b < WORD_W; b++) begin
				cnt += cur[b];
				if (rose[b]) begin
					newest = (newest + 1 >= LOG_DEPTH) ? 0 : newest + 1;
					slots[newest].code = CODE_W'(w*WORD_W + b + 1);
					slots[newest].t0   = ts0;
					slots[newest].t1   = ts1;
					slots[newest].t2   = ts2;
					view.save_request  = 1'b1;
				end
			end
		end
		sel   = (sel_in >= LOG_DEPTH) ? 0 : sel_in;
		shown = (newest + LOG_DEPTH - sel) % LOG_DEPTH;
		view.active_count   = COUNT_W'(cnt);
		view.select_used    = SEL_OUT_W'(sel);
		view.display_number = DISP_W'(sel*DISP_SCALE + slots[shown].code);
		view.time0          = slots[shown].t0;
		view.time1          = slots[shown].t1;
		view.time2          = slots[shown].t2;
		return view;
	endfunction

	task automatic flag(input string field, input logic [15:0] exp_val,
			input logic [15:0] act_val);
		mismatches++;
		if (mismatches <= 10)
			$display("result %0d: %s expected %0h, got %0h",
				result_no, field, exp_val, act_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_log();
			last_faults = '0;
			pending_views.delete();
			result_no   = 0;
			mismatches  = 0;
			outstanding <= 0;
		end else begin
			// Results first: nothing accepted at this edge can already be answered.
			if (out_ch.valid && out_ch.ready) begin
				got.active_count   = out_ch.active_count;
				got.save_request   = out_ch.save_request;
				got.select_used    = out_ch.select_used;
				got.display_number = out_ch.display_number;
				got.time0          = out_ch.display_time0;
				got.time1          = out_ch.display_time1;
				got.time2          = out_ch.display_time2;
				result_no++;
				if (pending_views.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d arrived with no tick pending", result_no);
				end else begin
					want = pending_views.pop_front();
					if (got.active_count != want.active_count)
						flag("active_count", 16'(want.active_count), 16'(got.active_count));
					if (got.save_request != want.save_request)
						flag("save_request", 16'(want.save_request), 16'(got.save_request));
					if (got.select_used != want.select_used)
						flag("select_used", 16'(want.select_used), 16'(got.select_used));
					if (got.display_number != want.display_number)
						flag("display_number", 16'(want.display_number),
							16'(got.display_number));
					if (got.time0 != want.time0)
						flag("display_time0", want.time0, got.time0);
					if (got.time1 != want.time1)
						flag("display_time1", want.time1, got.time1);
					if (got.time2 != want.time2)
						flag("display_time2", want.time2, got.time2);
				end
			end
			if (in_ch.valid && in_ch.ready)
				pending_views.push_back(log_tick(in_ch.fault_bits,
					in_ch.time_sec_hundredth, in_ch.time_hour_minute,
					in_ch.time_month_day, in_ch.clear_cmd, in_ch.display_select));
			outstanding <= pending_views.size();
		end
	end

endmodule

### dv/fault_event_logger_test.sv
// Top of the fault event logger testbench: clock, reset, tick stimulus and verdict.
// Depends on fel_pkg, fel_in_if, fel_out_if, fault_event_logger and fel_log_monitor.
module fault_event_logger_test;
	import fel_pkg::*;

	// Acceptance to loaded result when the output does not stall.
	localparam int unsigned RESULT_LATENCY = NUM_BITS + 2;
	localparam int unsigned RANDOM_TICKS   = 1100;
	// Slowest correct run: every tick waits out the longest source gap,
	// the block's own cycles and the longest sink stall; take that
	// several times over.
	localparam int unsigned CYCLE_LIMIT    = 3_000_000;

	localparam logic [FAULT_W-1:0] ALL_SET  = '1;
	localparam logic [FAULT_W-1:0] ODD_BITS = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [FAULT_W-1:0] EVN_BITS = 64'h5555_5555_5555_5555;

	logic               clk;
	logic               arst_n;
	int unsigned        mismatches;
	int unsigned        outstanding;
	int unsigned        cycle_count;
	logic               src_calm;
	logic               sink_calm;
	int unsigned        stall_left;
	int unsigned        stall_pick;
	int unsigned        sink_phase_left;
	logic [FAULT_W-1:0] faults_now;

	fel_in_if  in_ch ();
	fel_out_if out_ch ();

	fault_event_logger u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	fel_log_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Idle length: mostly none or a few cycles, now and then a long hold.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 24);
		return $urandom_range(40, 300);
	endfunction

	// Offer one tick, hold it until the block takes it, then maybe idle.
	// Valid stays high straight into the next tick when no gap is drawn.
	task automatic send_tick(input logic [FAULT_W-1:0] faults,
			input logic [TIME_W-1:0] ts0, input logic [TIME_W-1:0] ts1,
			input logic [TIME_W-1:0] ts2, input logic clr,
			input logic [SEL_W-1:0] sel);
		int unsigned gap;
		in_ch.valid              <= 1'b1;
		in_ch.fault_bits         <= faults;
		in_ch.time_sec_hundredth <= ts0;
		in_ch.time_hour_minute   <= ts1;
		in_ch.time_month_day     <= ts2;
		in_ch.clear_cmd          <= clr;
		in_ch.display_select     <= sel;
		do
			@(posedge clk);
		while (!in_ch.ready);
		gap = src_calm ? 0 : idle_len();
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sink side: random stalls, with calm stretches where ready stays high.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready    <= 1'b0;
			stall_left      <= 0;
			sink_calm       <= 1'b0;
			sink_phase_left <= 500;
		end else begin
			if (sink_phase_left == 0) begin
				sink_calm       <= ($urandom_range(0, 3) == 0);
				sink_phase_left <= $urandom_range(200, 2000);
			end else begin
				sink_phase_left <= sink_phase_left - 1;
			end
			if (stall_left != 0) begin
				stall_left   <= stall_left - 1;
				out_ch.ready <= (stall_left == 1);
			end else if (!sink_calm && $urandom_range(0, 5) == 0) begin
				stall_pick = idle_len();
				stall_left   <= stall_pick;
				out_ch.ready <= (stall_pick == 0);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run with a failure once the cycle limit is reached.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [FAULT_W-1:0] flips;
		logic [SEL_W-1:0]   sel;
		logic               clr;
		int unsigned        kind;
		int unsigned        word;

		arst_n                   <= 1'b0;
		in_ch.valid              <= 1'b0;
		in_ch.fault_bits         <= '0;
		in_ch.time_sec_hundredth <= '0;
		in_ch.time_hour_minute   <= '0;
		in_ch.time_month_day     <= '0;
		in_ch.clear_cmd          <= 1'b0;
		in_ch.display_select     <= '0;
		src_calm   = 1'b0;
		faults_now = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Fresh ring: nothing set, newest slot is empty.
		send_tick('0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0);
		// Every bit rises at once: 64 entries wrap the ring twice.
		send_tick(ALL_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0);
		// Hold the vector, walk the selector over its edges.
		send_tick(ALL_SET, 16'h1234, 16'h5678, 16'h9ABC, 1'b0, 16'd31);
		send_tick(ALL_SET, 16'h1234, 16'h5678, 16'h9ABC, 1'b0, 16'd32);
		send_tick(ALL_SET, 16'h1234, 16'h5678, 16'h9ABC, 1'b0, 16'hFFFF);
		// Clear with nothing new: save request alone, display shows an empty slot.
		send_tick(ALL_SET, 16'h0001, 16'h0002, 16'h0003, 1'b1, 16'd1);
		// Drop every bit, then bring back single bits at word boundaries.
		send_tick('0, 16'h0011, 16'h0022, 16'h0033, 1'b0, 16'd0);
		send_tick(64'h1, 16'h0101, 16'h0202, 16'h0303, 1'b0, 16'd0);
		send_tick(64'h8000_0000_0001_8001, 16'h0909, 16'h1010, 16'h1111, 1'b0, 16'd0);
		send_tick(64'h8000_0000_0001_8001, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd3);
		send_tick(64'h8000_0000_0001_8001, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd4);
		// Clear in the same tick as new rises: clear first, entries after.
		send_tick(ODD_BITS, 16'h5959, 16'h2323, 16'h1231, 1'b1, 16'd0);
		send_tick(EVN_BITS, 16'hA5A5, 16'h5A5A, 16'hC3C3, 1'b0, 16'd1);
		send_tick(ALL_SET, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'd2);
		send_tick('0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'd0);
		send_tick(64'h8000_0000_0000_0000, 16'h4242, 16'h2424, 16'h0F0F, 1'b0, 16'd0);
		faults_now = 64'h8000_0000_0000_0000;

		// Random part: mostly small changes against the last vector, so the
		// ring fills and wraps at a useful pace; the rest bursts and noise.
		for (int n = 0; n < RANDOM_TICKS; n++) begin
			if (n % 100 == 0)
				src_calm = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				flips = '0;
				repeat ($urandom_range(1, 3)) flips[$urandom_range(0, FAULT_W-1)] = 1'b1;
				faults_now = faults_now ^ flips;
			end else if (kind < 70) begin
				faults_now = {$urandom, $urandom};
			end else if (kind < 75) begin
				faults_now = '0;
			end else if (kind < 78) begin
				faults_now = ALL_SET;
			end else if (kind < 90) begin
				// hold: no rises this tick
			end else begin
				word = $urandom_range(0, FAULT_WORD_COUNT-1);
				faults_now[word*WORD_W +: WORD_W] =
					faults_now[word*WORD_W +: WORD_W] | WORD_W'($urandom);
			end
			clr = ($urandom_range(0, 99) < 4);
			kind = $urandom_range(0, 99);
			if (kind < 70)
				sel = SEL_W'($urandom_range(0, 3));
			else if (kind < 90)
				sel = SEL_W'($urandom_range(0, LOG_DEPTH-1));
			else if (kind < 95)
				sel = SEL_W'($urandom_range(LOG_DEPTH, 2*LOG_DEPTH-1));
			else
				sel = SEL_W'($urandom_range(0, 65535));
			send_tick(faults_now, TIME_W'($urandom), TIME_W'($urandom),
				TIME_W'($urandom), clr, sel);
		end
		in_ch.valid <= 1'b0;

		// Let the monitor see the last acceptance, drain, then allow for stray results.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (2*RESULT_LATENCY) @(posedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
